[rtl/grid_segment_collision_check_assert.svh]
// assertion macros for the grid segment collision check block
// used by the top level, no other dependencies
`ifndef GRID_SEGMENT_COLLISION_CHECK_ASSERT_SVH
`define GRID_SEGMENT_COLLISION_CHECK_ASSERT_SVH

// same-cycle implication
`define GSCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GSCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gscc_pkg.sv]
// shared constants and types for the grid segment collision check block
// no dependencies
package gscc_pkg;

  localparam int GRID_WIDTH_DEF     = 256;
  localparam int GRID_HEIGHT_DEF    = 256;
  localparam int STEP_FRAC_BITS_DEF = 8;

  localparam int COORD_W = 8;
  localparam int CODE_W  = 3;
  localparam int STEP_W  = 9;
  localparam int Q_W     = 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SAMPLE_STEP = 3'd0;
  localparam logic [STEP_W-1:0]     SAMPLE_STEP_RST  = 9'd256;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_SEGMENT = 2'd1;
  localparam logic [1:0] ACT_POINT   = 2'd2;

  localparam logic [CODE_W-1:0] CODE_OBSTACLE = 3'd1;
  localparam logic [CODE_W-1:0] CODE_GOAL_A   = 3'd6;
  localparam logic [CODE_W-1:0] CODE_GOAL_B   = 3'd7;

  typedef struct packed {
    logic busy;
    logic done;
  } gscc_div_st_t;

endpackage

[rtl/gscc_if.sv]
// item channel interfaces for the grid segment collision check block
// depends on gscc_pkg
interface gscc_in_if import gscc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [COORD_W-1:0] col_a;
  logic [COORD_W-1:0] row_a;
  logic [COORD_W-1:0] col_b;
  logic [COORD_W-1:0] row_b;
  logic [CODE_W-1:0]  cell_code;

  modport source (output valid, action, col_a, row_a, col_b, row_b, cell_code, input ready);
  modport sink   (input valid, action, col_a, row_a, col_b, row_b, cell_code, output ready);
endinterface

interface gscc_out_if ();
  logic valid;
  logic ready;
  logic path_free;
  logic cell_free;
  logic goal_cell;

  modport source (output valid, path_free, cell_free, goal_cell, input ready);
  modport sink   (input valid, path_free, cell_free, goal_cell, output ready);
endinterface

[rtl/gscc_grid_mem.sv]
// occupancy grid store, one write port and one registered read port
// depends on gscc_pkg
module gscc_grid_mem import gscc_pkg::*; #(
  parameter int DEPTH  = GRID_WIDTH_DEF * GRID_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CODE_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem [DEPTH];
  logic [CODE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/gscc_div.sv]
// restoring divider, one quotient bit per cycle
// depends on gscc_pkg; quotient must fit in Q_W bits
module gscc_div import gscc_pkg::*; #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot,
  output logic             rem_nz,
  output gscc_div_st_t     st
);

  localparam int CNT_W = $clog2(Q_W);

  logic [NUM_W-1:0] rem_r;
  logic [NUM_W-1:0] dsh_r;
  logic [Q_W-1:0]   quot_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             fits;

  assign fits = rem_r >= dsh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        dsh_r  <= NUM_W'(den) << (Q_W - 1);
        quot_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_r - dsh_r;
        end
        quot_r <= {quot_r[Q_W-2:0], fits};
        dsh_r  <= dsh_r >> 1;
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quot   = quot_r;
  assign rem_nz = rem_r != '0;
  assign st     = '{busy: busy_r, done: done_r};

endmodule

[rtl/grid_segment_collision_check.sv]
// grid segment collision check, top level: sequencer, config register, result register
// depends on gscc_pkg, gscc_if, gscc_grid_mem, gscc_div and the assertion macro header
//
// in_if takes one item at a time: write a cell code, check a segment, or check a point.
// every item gives one result item on out_if, taken when valid and ready are both high.
// the config port holds sample_step at byte address 0, written with psel, penable and
// pwrite high; pready is always high and reads return the register.
// write and unused actions go straight to the result; a point check first reads the grid.
// segment check: n samples, n = ceil(|d| * 2^STEP_FRAC_BITS / sample_step) along the
// walked axis, the walk stopping early at an obstacle; a column-only segment steps,
// reads the grid and checks for each sample; any other also passes the multiply and
// the divider that gives the row of each sample before the grid read.
// a new item is taken only once the previous one has finished; its result can still
// be waiting in the output register while the next item is accepted.
// after reset the grid is cleared one cell a cycle, all GRID_WIDTH * GRID_HEIGHT cells
// (65536 by default), with in_if not ready; config writes are taken throughout.
// a stalled receiver holds the result register and the block waits with its next result.
`include "grid_segment_collision_check_assert.svh"

module grid_segment_collision_check import gscc_pkg::*; #(
  parameter int GRID_WIDTH     = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT    = GRID_HEIGHT_DEF,
  parameter int STEP_FRAC_BITS = STEP_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gscc_in_if.sink               in_if,
  gscc_out_if.source            out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int POS_W  = COORD_W + STEP_FRAC_BITS;
  localparam int CMP_W  = (POS_W > STEP_W) ? POS_W : STEP_W;
  localparam int NUM_W  = POS_W + COORD_W;
  localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_STEP, S_MUL, S_DWAIT, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t             state_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [STEP_W-1:0]  sample_step_r;
  logic               out_valid_r, out_path_r, out_free_r, out_goal_r;
  logic               res_path_r, res_free_r, res_goal_r;
  logic [1:0]         act_r;
  logic               vert_r, y_up_r, oob_r;
  logic [POS_W-1:0]   pos_r, goal_r, base_r;
  logic [COORD_W-1:0] dx_r, dy_r, sy_r, cur_col_r, cur_row_r;

  logic               in_acc, out_take, cfg_wr;
  logic [STEP_W-1:0]  step_eff;
  logic [POS_W-1:0]   pos_adv, t_abs, den;
  logic [NUM_W-1:0]   mul_prod;
  logic [Q_W-1:0]     div_q;
  logic               div_rnz, div_start;
  gscc_div_st_t       div_st;
  logic [CODE_W-1:0]  mem_rdata, code;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CODE_W-1:0]  mem_wdata;
  logic [COORD_W-1:0] row_calc;

  function automatic logic in_grid(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    return (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row);
    return ADDR_W'(32'(row) * GRID_WIDTH + 32'(col));
  endfunction

  // move toward the goal by one step, never past it
  function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0]  pos,
                                               input logic [POS_W-1:0]  goal,
                                               input logic [STEP_W-1:0] step);
    logic [CMP_W-1:0] span;
    logic [CMP_W-1:0] stp;
    stp = CMP_W'(step);
    if (pos < goal) begin
      span = CMP_W'(goal - pos);
      return (span <= stp) ? goal : pos + POS_W'(step);
    end
    span = CMP_W'(pos - goal);
    return (span <= stp) ? goal : pos - POS_W'(step);
  endfunction

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_take = out_valid_r && out_if.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;

  assign in_if.ready      = state_r == S_IDLE;
  assign out_if.valid     = out_valid_r;
  assign out_if.path_free = out_path_r;
  assign out_if.cell_free = out_free_r;
  assign out_if.goal_cell = out_goal_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_SAMPLE_STEP) ? CFG_DATA_W'(sample_step_r) : '0;

  assign step_eff = (sample_step_r == '0) ? STEP_W'(1) : sample_step_r;
  assign pos_adv  = advance(pos_r, goal_r, step_eff);
  assign t_abs    = (pos_r > base_r) ? pos_r - base_r : base_r - pos_r;
  assign mul_prod = dy_r * t_abs;
  assign den      = POS_W'(dx_r) << STEP_FRAC_BITS;
  assign div_start = state_r == S_MUL;
  assign row_calc = y_up_r ? sy_r + div_q : sy_r - div_q - COORD_W'(div_rnz);
  assign code     = oob_r ? '0 : mem_rdata;

  // grid write port: clearing pass after reset, else cell writes
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = in_acc && (in_if.action == ACT_WRITE) && in_grid(in_if.col_a, in_if.row_a);
      mem_waddr = addr_of(in_if.col_a, in_if.row_a);
      mem_wdata = in_if.cell_code;
    end
  end

  assign mem_re = state_r == S_READ;

  gscc_grid_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_of(cur_col_r, cur_row_r)),
    .rdata (mem_rdata)
  );

  gscc_div #(
    .NUM_W (NUM_W),
    .DEN_W (POS_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (mul_prod),
    .den    (den),
    .quot   (div_q),
    .rem_nz (div_rnz),
    .st     (div_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      sample_step_r <= SAMPLE_STEP_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr == ADDR_SAMPLE_STEP) begin
        sample_step_r <= cfg_pwdata[STEP_W-1:0];
      end
      if (out_take && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            act_r      <= in_if.action;
            res_path_r <= (in_if.action == ACT_SEGMENT) && (in_if.col_a == in_if.col_b) &&
                          (in_if.row_a == in_if.row_b);
            res_free_r <= 1'b0;
            res_goal_r <= 1'b0;
            cur_col_r  <= in_if.col_a;
            cur_row_r  <= in_if.row_a;
            sy_r       <= in_if.row_a;
            y_up_r     <= in_if.row_b >= in_if.row_a;
            vert_r     <= in_if.col_a == in_if.col_b;
            dx_r <= (in_if.col_a > in_if.col_b) ? in_if.col_a - in_if.col_b
                                                : in_if.col_b - in_if.col_a;
            dy_r <= (in_if.row_a > in_if.row_b) ? in_if.row_a - in_if.row_b
                                                : in_if.row_b - in_if.row_a;
            if (in_if.col_a == in_if.col_b) begin
              pos_r  <= POS_W'(in_if.row_a) << STEP_FRAC_BITS;
              goal_r <= POS_W'(in_if.row_b) << STEP_FRAC_BITS;
            end else begin
              pos_r  <= POS_W'(in_if.col_a) << STEP_FRAC_BITS;
              goal_r <= POS_W'(in_if.col_b) << STEP_FRAC_BITS;
            end
            base_r <= POS_W'(in_if.col_a) << STEP_FRAC_BITS;
            case (in_if.action)
              ACT_SEGMENT: begin
                if (in_if.col_a == in_if.col_b && in_if.row_a == in_if.row_b) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_STEP;
                end
              end
              ACT_POINT: state_r <= S_READ;
              default:   state_r <= S_DONE;
            endcase
          end
        end
        S_STEP: begin
          pos_r <= pos_adv;
          if (vert_r) begin
            cur_row_r <= pos_adv[POS_W-1 -: COORD_W];
            state_r   <= S_READ;
          end else begin
            cur_col_r <= pos_adv[POS_W-1 -: COORD_W];
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_st.done) begin
            cur_row_r <= row_calc;
            state_r   <= S_READ;
          end
        end
        S_READ: begin
          oob_r   <= !in_grid(cur_col_r, cur_row_r);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (act_r == ACT_POINT) begin
            res_free_r <= code != CODE_OBSTACLE;
            res_goal_r <= (code == CODE_GOAL_A) || (code == CODE_GOAL_B);
            state_r    <= S_DONE;
          end else if (code == CODE_OBSTACLE) begin
            res_path_r <= 1'b0;
            state_r    <= S_DONE;
          end else if (pos_r == goal_r) begin
            res_path_r <= 1'b1;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r <= 1'b1;
            out_path_r  <= res_path_r;
            out_free_r  <= res_free_r;
            out_goal_r  <= res_goal_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  `GSCC_ASSERT_NEXT(a_acc_leaves_idle, clk, rst_n, in_acc, state_r != S_IDLE, "item accepted but sequencer stayed idle")
  `GSCC_ASSERT_IMPL(a_grid_write_when_idle, clk, rst_n, mem_we, (state_r == S_CLEAR) || (state_r == S_IDLE), "grid written during a check")
  `GSCC_ASSERT_IMPL(a_div_done_in_wait, clk, rst_n, div_st.done, state_r == S_DWAIT, "divider finished outside its wait state")
  `GSCC_ASSERT_NEXT(a_done_loads_result, clk, rst_n, (state_r == S_DONE) && (!out_valid_r || out_if.ready), out_valid_r && (state_r == S_IDLE), "finished item not moved to the result register")

endmodule

[bench/tb_grid_segment_collision_check.sv]
// testbench for grid_segment_collision_check: random and directed cell writes, segment and
// point checks against an internal grid predictor, with random stalls on both channels
// depends on gscc_pkg, gscc_if and the rtl top level
module tb_grid_segment_collision_check import gscc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = STEP_FRAC_BITS_DEF;
  localparam int GRID_CELLS = GRID_WIDTH_DEF * GRID_HEIGHT_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int N_PHASES = 5;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] col_a;
    logic [COORD_W-1:0] row_a;
    logic [COORD_W-1:0] col_b;
    logic [COORD_W-1:0] row_b;
    logic [CODE_W-1:0]  cell_code;
  } grid_op_t;

  typedef struct packed {
    logic path_free;
    logic cell_free;
    logic goal_cell;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  gscc_in_if  in_ch ();
  gscc_out_if out_ch ();

  grid_segment_collision_check u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  logic [CODE_W-1:0] grid_model [GRID_CELLS];
  logic [STEP_W-1:0] step_setting;

  grid_op_t ops_pending [$];
  verdict_t verdicts_due [$];

  grid_op_t op_now;
  logic     op_live = 1'b0;
  int       op_gap = 0;
  int       send_burst = 0;
  int       recv_burst = 0;
  int       rx_stall = 0;
  int       rx_hold = 0;
  int       hold_asked = 0;
  int       hold_given = 0;
  int       quiet_cycles = 0;
  int       mismatches = 0;
  int       n_writes = 0;
  int       n_segments = 0;
  int       n_blocked = 0;
  int       n_points = 0;
  int       n_unused = 0;
  int       n_settings = 0;

  function automatic int draw_wait(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [CODE_W-1:0] code_at(int unsigned col, int unsigned row);
    if (col >= GRID_WIDTH_DEF || row >= GRID_HEIGHT_DEF) return '0;
    return grid_model[row * GRID_WIDTH_DEF + col];
  endfunction

  function automatic int unsigned move_toward(int unsigned p, int unsigned tgt,
                                              int unsigned stride);
    if (p < tgt) return (tgt - p <= stride) ? tgt : p + stride;
    return (p - tgt <= stride) ? tgt : p - stride;
  endfunction

  function automatic logic segment_clear(int unsigned sx, int unsigned sy,
                                         int unsigned gx, int unsigned gy);
    int unsigned stride, p, tgt, base, dx, dy, den, t, num, row;
    stride = (step_setting == '0) ? 1 : int'(step_setting);
    if (sx == gx && sy == gy) return 1'b1;
    if (sx == gx) begin
      p = sy << FRAC;
      tgt = gy << FRAC;
      while (p != tgt) begin
        p = move_toward(p, tgt, stride);
        if (code_at(sx, p >> FRAC) == CODE_OBSTACLE) return 1'b0;
      end
      return 1'b1;
    end
    base = sx << FRAC;
    dx = (sx > gx) ? sx - gx : gx - sx;
    dy = (sy > gy) ? sy - gy : gy - sy;
    den = dx << FRAC;
    p = base;
    tgt = gx << FRAC;
    while (p != tgt) begin
      p = move_toward(p, tgt, stride);
      t = (p > base) ? p - base : base - p;
      num = dy * t;
      row = (gy >= sy) ? sy + num / den : sy - (num + den - 1) / den;
      if (code_at(p >> FRAC, row) == CODE_OBSTACLE) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic verdict_t predict_verdict(grid_op_t op);
    verdict_t v;
    logic [CODE_W-1:0] c;
    v = '0;
    case (op.action)
      ACT_WRITE: begin
        grid_model[int'(op.row_a) * GRID_WIDTH_DEF + int'(op.col_a)] = op.cell_code;
        n_writes++;
      end
      ACT_SEGMENT: begin
        v.path_free = segment_clear(op.col_a, op.row_a, op.col_b, op.row_b);
        n_segments++;
        if (!v.path_free) n_blocked++;
      end
      ACT_POINT: begin
        c = code_at(op.col_a, op.row_a);
        v.cell_free = (c != CODE_OBSTACLE);
        v.goal_cell = (c == CODE_GOAL_A) || (c == CODE_GOAL_B);
        n_points++;
      end
      default: n_unused++;
    endcase
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] offset_coord(int base, int off);
    int v;
    v = $urandom_range(0, 1) ? base + off : base - off;
    if (v < 0 || v > 255) v = 2 * base - v;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    return ($urandom_range(0, 3) != 0) ? COORD_W'($urandom_range(96, 127))
                                       : COORD_W'($urandom_range(0, 255));
  endfunction

  function automatic grid_op_t random_op(logic [STEP_W-1:0] step_cfg);
    grid_op_t op;
    int stride, reach, pick, sub, r;
    stride = (step_cfg == '0) ? 1 : int'(step_cfg);
    op.col_a = pick_coord();
    op.row_a = pick_coord();
    op.col_b = COORD_W'($urandom_range(0, 255));
    op.row_b = COORD_W'($urandom_range(0, 255));
    op.cell_code = CODE_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op.action = ACT_WRITE;
      r = $urandom_range(0, 9);
      if (r < 4) op.cell_code = CODE_OBSTACLE;
      else if (r == 4) op.cell_code = CODE_GOAL_A;
      else if (r == 5) op.cell_code = CODE_GOAL_B;
    end else if (pick < 70) begin
      op.action = ACT_SEGMENT;
      sub = $urandom_range(0, 19);
      if (sub == 0) begin
        op.col_b = op.col_a;
        op.row_b = op.row_a;
      end else if (sub < 6) begin
        reach = 150 * stride / 256;
        if (reach < 1) reach = 1;
        if (reach > 255) reach = 255;
        op.col_b = op.col_a;
        op.row_b = offset_coord(op.row_a, $urandom_range(1, reach));
      end else begin
        reach = 48 * stride / 256;
        if (stride >= 128 && $urandom_range(0, 11) == 0) reach = 255;
        if (reach < 1) reach = 1;
        if (reach > 255) reach = 255;
        op.col_b = offset_coord(op.col_a, $urandom_range(1, reach));
        if ($urandom_range(0, 3) != 0) op.row_b = offset_coord(op.row_a, $urandom_range(0, 32));
      end
    end else if (pick < 95) begin
      op.action = ACT_POINT;
    end else begin
      op.action = ACT_UNUSED;
    end
    return op;
  endfunction

  task automatic push_op(logic [1:0] act, int ca, int ra, int cb, int rb, int code);
    grid_op_t op;
    op.action = act;
    op.col_a = COORD_W'(ca);
    op.row_a = COORD_W'(ra);
    op.col_b = COORD_W'(cb);
    op.row_b = COORD_W'(rb);
    op.cell_code = CODE_W'(code);
    ops_pending.push_back(op);
  endtask

  task automatic wait_idle();
    while (ops_pending.size() != 0 || op_live || verdicts_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_sample_step(logic [STEP_W-1:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = ADDR_SAMPLE_STEP;
    cfg_pwdata = CFG_DATA_W'(value);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    step_setting = value;
    n_settings++;
  endtask

  task automatic note_mismatch(string what, verdict_t want, verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) at %0t: expected path_free %0b cell_free %0b goal_cell %0b, got %0b %0b %0b",
               what, $realtime, want.path_free, want.cell_free, want.goal_cell,
               got.path_free, got.cell_free, got.goal_cell);
  endtask

  always @(posedge clk) begin : driver
    grid_op_t shown;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      verdicts_due.push_back(predict_verdict(op_now));
      op_live = 1'b0;
      op_gap = draw_wait(send_burst);
    end
    @(negedge clk);
    if (!op_live) begin
      if (op_gap > 0) op_gap--;
      else if (ops_pending.size() > 0) begin
        op_now = ops_pending.pop_front();
        op_live = 1'b1;
      end
    end
    shown = op_live ? op_now : grid_op_t'($urandom);
    in_ch.valid = op_live;
    in_ch.action = shown.action;
    in_ch.col_a = shown.col_a;
    in_ch.row_a = shown.row_a;
    in_ch.col_b = shown.col_b;
    in_ch.row_b = shown.row_b;
    in_ch.cell_code = shown.cell_code;
  end

  always @(posedge clk) begin : monitor
    verdict_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.path_free = out_ch.path_free;
      got.cell_free = out_ch.cell_free;
      got.goal_cell = out_ch.goal_cell;
      if (verdicts_due.size() == 0) begin
        note_mismatch("no item outstanding", '0, got);
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) note_mismatch("wrong field", want, got);
      end
      rx_stall = draw_wait(recv_burst);
    end
    @(negedge clk);
    if (hold_asked != hold_given) begin
      hold_given++;
      rx_hold = HOLD_CYCLES;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ch.ready = 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, verdicts_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [STEP_W-1:0] phase_step [N_PHASES];
    int phase_len [N_PHASES];
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_WRITE;
    in_ch.col_a = '0;
    in_ch.row_a = '0;
    in_ch.col_b = '0;
    in_ch.row_b = '0;
    in_ch.cell_code = '0;
    out_ch.ready = 1'b0;
    foreach (grid_model[i]) grid_model[i] = '0;
    step_setting = SAMPLE_STEP_RST;
    phase_step[0] = 9'd1;
    phase_step[1] = 9'd0;
    phase_step[2] = 9'd511;
    phase_step[3] = STEP_W'($urandom_range(2, 255));
    phase_step[4] = SAMPLE_STEP_RST;
    phase_len = '{90, 60, 150, 170, 200};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed items at the reset step size
    push_op(ACT_POINT, 0, 0, 255, 255, 7);
    push_op(ACT_WRITE, 255, 255, 0, 0, CODE_GOAL_B);
    push_op(ACT_POINT, 255, 255, 0, 0, 0);
    push_op(ACT_WRITE, 0, 255, 0, 0, CODE_GOAL_A);
    push_op(ACT_POINT, 0, 255, 0, 0, 0);
    push_op(ACT_WRITE, 255, 0, 0, 0, CODE_OBSTACLE);
    push_op(ACT_POINT, 255, 0, 0, 0, 0);
    push_op(ACT_WRITE, 10, 10, 0, 0, CODE_OBSTACLE);
    push_op(ACT_WRITE, 12, 11, 0, 0, 2);
    push_op(ACT_WRITE, 13, 11, 0, 0, 3);
    push_op(ACT_WRITE, 14, 11, 0, 0, 4);
    push_op(ACT_WRITE, 15, 11, 0, 0, 5);
    push_op(ACT_WRITE, 255, 255, 0, 0, 0);
    push_op(ACT_POINT, 255, 255, 0, 0, 0);
    push_op(ACT_SEGMENT, 5, 5, 5, 5, 0);
    push_op(ACT_SEGMENT, 0, 10, 20, 10, 0);
    push_op(ACT_SEGMENT, 10, 0, 10, 20, 0);
    push_op(ACT_SEGMENT, 11, 20, 11, 0, 0);
    push_op(ACT_SEGMENT, 20, 20, 0, 0, 0);
    push_op(ACT_SEGMENT, 255, 0, 200, 0, 0);
    push_op(ACT_SEGMENT, 0, 0, 255, 255, 0);
    push_op(ACT_SEGMENT, 0, 255, 255, 0, 0);
    push_op(ACT_SEGMENT, 255, 255, 0, 255, 0);
    push_op(ACT_UNUSED, 255, 255, 255, 255, 7);
    wait_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_sample_step(phase_step[ph]);
      for (int k = 0; k < phase_len[ph]; k++) ops_pending.push_back(random_op(step_setting));
      // receiver holds off while the sender keeps offering
      if (ph == 2) hold_asked++;
      wait_idle();
    end

    repeat (64) @(posedge clk);
    $display("covered %0d writes, %0d segment checks (%0d blocked), %0d point checks, %0d unused",
             n_writes, n_segments, n_blocked, n_points, n_unused);
    $display("over %0d sample_step settings incl. 0, 1 and 511; %0d mismatches",
             n_settings, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
